// File: rtl/gbcy_pkg.sv
`default_nettype none

package gbcy_pkg;

  // Field and state widths
  localparam int RawW   = 16;
  localparam int OpW    = 2;
  localparam int ScaleW = 32;
  localparam int ThrW   = 31;
  localparam int CountW = 10;
  localparam int StepW  = 32;
  localparam int RateW  = 32;
  localparam int SumW   = 42;
  localparam int HeadW  = 25;
  localparam int HSumW  = 34;
  localparam int WideW  = 40;
  localparam int ProdW  = 64;
  localparam int CfgIdxW = 2;

  // Register reset values
  localparam logic [ScaleW-1:0] RateScaleRst = 32'd1024000;
  localparam logic [ThrW-1:0]   NoiseThrRst  = 31'd16384;
  localparam logic [CountW-1:0] SampleCntRst = 10'd200;
  localparam logic [StepW-1:0]  TimeStepRst  = 32'd21474836;

  localparam logic [CountW-1:0] CountMax = 10'd1023;

  // Half and full turn in Q16.16 degrees
  localparam logic signed [HSumW-1:0] Deg180 = 34'sd11796480;
  localparam logic signed [HSumW-1:0] Deg360 = 34'sd23592960;

  typedef enum logic [OpW-1:0] {
    OP_CAL     = 2'd0,
    OP_UPDATE  = 2'd1,
    OP_YAW_CLR = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_RATE_SCALE = 2'd0,
    REG_NOISE_THR  = 2'd1,
    REG_SAMPLE_CNT = 2'd2,
    REG_TIME_STEP  = 2'd3
  } reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_RAW,
    ST_EVAL,
    ST_MUL_STEP,
    ST_INTEG,
    ST_WRAP,
    ST_DIV_GO,
    ST_DIV,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  // Saturate a wide signed value to 32 bit signed
  function automatic logic signed [RateW-1:0] sat32(input logic signed [WideW-1:0] v);
    logic signed [WideW-1:0] hi;
    logic signed [WideW-1:0] lo;
    hi = WideW'(signed'({1'b0, {(RateW-1){1'b1}}}));
    lo = -hi - WideW'(1);
    if (v > hi) begin
      sat32 = RateW'(hi);
    end else if (v < lo) begin
      sat32 = RateW'(lo);
    end else begin
      sat32 = v[RateW-1:0];
    end
  endfunction

endpackage

`default_nettype wire

// File: rtl/gbcy_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle
module gbcy_div import gbcy_pkg::*; #(
  parameter int DividendW = SumW,
  parameter int DivisorW  = CountW
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [DividendW-1:0] dividend_i,
  input  wire logic [DivisorW-1:0]  divisor_i,
  output logic      [DividendW-1:0] quotient_o,
  output div_status_t               status_o
);

  localparam int CntW = $clog2(DividendW + 1);

  logic [DivisorW-1:0]  rem_q, rem_d;
  logic [DividendW-1:0] quo_q, quo_d;
  logic [DivisorW-1:0]  dvs_q, dvs_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;

  logic [DivisorW:0] trial;
  logic [DivisorW:0] diff;
  logic              ge;

  assign trial = {rem_q, quo_q[DividendW-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = trial >= {1'b0, dvs_q};

  // Load on start, then shift one bit in per cycle
  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
      cnt_d  = CntW'(DividendW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? diff[DivisorW-1:0] : trial[DivisorW-1:0];
      quo_d = {quo_q[DividendW-2:0], ge};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign quotient_o    = quo_q;
  assign status_o.busy = busy_q;
  assign status_o.done = done_q;

endmodule

`default_nettype wire

// File: rtl/gyro_bias_calibrate_yaw_integrate_unit.sv
`default_nettype none

// Channel   Direction  tdata (low bit up)                       tuser
// s_axis    in         raw_rate[15:0]                           opcode[1:0]
// m_axis    out        yaw_angle[24:0] corrected_rate[56:25]    calibrated[0]
//                      bias_value[88:57], zero pad[95:89]
// cfg       in         cfg_we_i, cfg_idx_i, cfg_data_i          -
//
// One transaction at a time through a shared 33x33 multiplier and a small sequencer.
// Update steps: idle, raw multiply, evaluate, step multiply, integrate, wrap, output;
// calibrate, yaw clear and no-op go from evaluate to output. The calibrate item that
// completes the bias runs the serial divider before output.
// Reset clears heading, bias, sum, count and the calibrated flag at once.
// A stalled output holds the block: no new input is taken until the result leaves.
module gyro_bias_calibrate_yaw_integrate_unit import gbcy_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [RawW-1:0]    s_axis_tdata,   // raw_rate[15:0]
  input  wire logic [OpW-1:0]     s_axis_tuser,   // opcode[1:0]
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic [95:0]             m_axis_tdata,   // yaw_angle, corrected_rate, bias_value
  output logic                    m_axis_tuser,   // calibrated
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [31:0]        cfg_data_i
);

  state_e state_q, state_d;

  logic [ScaleW-1:0] rate_scale_q;
  logic [ThrW-1:0]   noise_thr_q;
  logic [CountW-1:0] sample_cnt_q;
  logic [StepW-1:0]  time_step_q;

  logic        [RawW-1:0]  raw_q;
  op_e                     op_q;
  logic signed [ProdW-1:0] prod_q, prod_d;
  logic signed [RateW-1:0] corr_q, corr_d;
  logic signed [HSumW-1:0] hsum_q, hsum_d;
  logic signed [HeadW-1:0] heading_q, heading_d;
  logic signed [RateW-1:0] bias_q, bias_d;
  logic signed [SumW-1:0]  sum_q, sum_d;
  logic        [CountW-1:0] count_q, count_d;
  logic                    done_q, done_d;

  // Shared multiplier
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] mul_p;

  logic signed [RateW-1:0] rate;
  logic        [32:0]      rate_mag;
  logic        [CountW-1:0] need;
  logic                    cal_take;
  logic        [CountW-1:0] count_next;
  logic                    cal_complete;
  logic signed [WideW-1:0] corr_wide;

  logic signed [HSumW-1:0] wrap1, wrap2, wrap3;

  logic                    div_start;
  logic        [SumW-1:0]  div_dividend;
  logic        [SumW-1:0]  div_quo;
  div_status_t             div_status;
  logic        [RateW-1:0] quo_low;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_scale_q <= RateScaleRst;
      noise_thr_q  <= NoiseThrRst;
      sample_cnt_q <= SampleCntRst;
      time_step_q  <= TimeStepRst;
    end else if (cfg_we_i) begin
      case (reg_e'(cfg_idx_i))
        REG_RATE_SCALE: rate_scale_q <= cfg_data_i;
        REG_NOISE_THR:  noise_thr_q  <= cfg_data_i[ThrW-1:0];
        REG_SAMPLE_CNT: sample_cnt_q <= cfg_data_i[CountW-1:0];
        REG_TIME_STEP:  time_step_q  <= cfg_data_i[StepW-1:0];
        default: ;
      endcase
    end
  end

  // Select multiplier operands by step
  always_comb begin
    if (state_q == ST_MUL_STEP) begin
      mul_a = {corr_q[RateW-1], corr_q};
      mul_b = signed'({1'b0, time_step_q});
    end else begin
      mul_a = 33'(signed'(raw_q));
      mul_b = signed'({1'b0, rate_scale_q});
    end
  end
  assign mul_p = mul_a * mul_b;

  // Scaled rate: floor shift by 8, then saturate
  assign rate     = sat32(prod_q[47:8]);
  assign rate_mag = rate[RateW-1] ? 33'(-{rate[RateW-1], rate}) : {1'b0, rate};
  assign need     = (sample_cnt_q == '0) ? CountW'(1) : sample_cnt_q;
  assign cal_take = (rate_mag < {2'b00, noise_thr_q}) && (count_q != CountMax);
  assign count_next   = cal_take ? count_q + CountW'(1) : count_q;
  assign cal_complete = (op_q == OP_CAL) && !done_q && (count_next >= need);
  assign corr_wide    = WideW'(rate) - WideW'(bias_q);

  // Wrap once into a half turn either side, then clamp
  always_comb begin
    wrap1 = (hsum_q > Deg180) ? hsum_q - Deg360 : hsum_q;
    wrap2 = (wrap1 < -Deg180) ? wrap1 + Deg360 : wrap1;
    if (wrap2 > Deg180) begin
      wrap3 = Deg180;
    end else if (wrap2 < -Deg180) begin
      wrap3 = -Deg180;
    end else begin
      wrap3 = wrap2;
    end
  end

  assign div_dividend = sum_q[SumW-1] ? SumW'(-sum_q) : SumW'(sum_q);
  assign quo_low      = div_quo[RateW-1:0];

  gbcy_div #(
    .DividendW(SumW),
    .DivisorW (CountW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (count_q),
    .quotient_o(div_quo),
    .status_o  (div_status)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (s_axis_tvalid) state_d = ST_MUL_RAW;
      ST_MUL_RAW:  state_d = ST_EVAL;
      ST_EVAL: begin
        if (op_q == OP_UPDATE) begin
          state_d = ST_MUL_STEP;
        end else if (cal_complete) begin
          state_d = ST_DIV_GO;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_MUL_STEP: state_d = ST_INTEG;
      ST_INTEG:    state_d = ST_WRAP;
      ST_WRAP:     state_d = ST_OUT;
      ST_DIV_GO:   state_d = ST_DIV;
      ST_DIV:      if (div_status.done) state_d = ST_OUT;
      ST_OUT:      if (m_axis_tready) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Handshake and divider control
  always_comb begin
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    div_start     = 1'b0;
    case (state_q)
      ST_IDLE:   s_axis_tready = 1'b1;
      ST_OUT:    m_axis_tvalid = 1'b1;
      ST_DIV_GO: div_start     = 1'b1;
      default: ;
    endcase
  end

  // Datapath updates per step
  always_comb begin
    prod_d    = prod_q;
    corr_d    = corr_q;
    hsum_d    = hsum_q;
    heading_d = heading_q;
    bias_d    = bias_q;
    sum_d     = sum_q;
    count_d   = count_q;
    done_d    = done_q;
    case (state_q)
      ST_MUL_RAW, ST_MUL_STEP: prod_d = mul_p[ProdW-1:0];
      ST_EVAL: begin
        corr_d = '0;
        case (op_q)
          OP_CAL: begin
            if (!done_q) begin
              if (cal_take) begin
                sum_d   = sum_q + SumW'(rate);
                count_d = count_next;
              end
              if (cal_complete) done_d = 1'b1;
            end
          end
          OP_UPDATE:  corr_d    = sat32(corr_wide);
          OP_YAW_CLR: heading_d = '0;
          default: ;
        endcase
      end
      ST_INTEG: hsum_d    = HSumW'(heading_q) + HSumW'(signed'(prod_q[63:32]));
      ST_WRAP:  heading_d = wrap3[HeadW-1:0];
      ST_DIV: begin
        if (div_status.done) begin
          bias_d = sum_q[SumW-1] ? -signed'(quo_low) : signed'(quo_low);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      heading_q <= '0;
      bias_q    <= '0;
      sum_q     <= '0;
      count_q   <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      heading_q <= heading_d;
      bias_q    <= bias_d;
      sum_q     <= sum_d;
      count_q   <= count_d;
      done_q    <= done_d;
    end
  end

  // Capture the transaction and hold working values
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      raw_q <= s_axis_tdata;
      op_q  <= op_e'(s_axis_tuser);
    end
    prod_q <= prod_d;
    corr_q <= corr_d;
    hsum_q <= hsum_d;
  end

  assign m_axis_tdata = {7'b0, bias_q, corr_q, heading_q};
  assign m_axis_tuser = done_q;

  // Checks
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while a result is pending");

  a_heading_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (HSumW'(heading_q) <= Deg180) && (HSumW'(heading_q) >= -Deg180))
    else $error("heading outside half turn");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> (count_q != '0))
    else $error("bias division by zero count");

  a_back_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready) |=> s_axis_tready)
    else $error("not ready after result taken");

endmodule

`default_nettype wire
